// ===== sv/api_frame_deframer_with_fifo_unit_assert.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef API_FRAME_DEFRAMER_WITH_FIFO_UNIT_ASSERT_SVH
`define API_FRAME_DEFRAMER_WITH_FIFO_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define AFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cond is never true outside reset.
`define AFD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AFD_ASSERT(lbl, prop, msg)
`define AFD_NEVER(lbl, cond, msg)
`endif

`endif

// ===== sv/afd_pkg.sv =====
package afd_pkg;

  // Buffer geometry
  localparam int DEPTH  = 32;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = 6;

  // Frame delimiter
  localparam logic [7:0] FRAME_START = 8'h7E;

  // Input operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_DRAIN = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_PUT_OK  = 2'd0;
  localparam logic [1:0] KIND_DROPPED = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

endpackage

// ===== sv/afd_ram.sv =====
module afd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/api_frame_deframer_with_fifo_unit.sv =====
// Byte buffer with API frame deframer.
// Input channel: in_op selects put (store in_rx_byte), drain or flush; an
// item is taken when in_valid is high and in_stall is low. Output channel:
// one word per result (kind, payload byte, frame end, fill level, full).
// Put and flush give one result, registered in the cycle after acceptance.
// A drain reads the buffer memory one byte at a time: each held byte goes
// through a memory read, then a parse, which can wait while the output word
// is stalled; the drain ends with a done word. Payload words come out as the
// parser meets them; header, checksum and out-of-frame bytes give none.
// One item is in work at a time; in_stall stays high until the last result
// of the current item has been loaded into the output register.
// When the receiver stalls, the output word holds and the block waits
// before loading the next word; no word is lost.
// Reset empties the buffer and puts the parser in its idle phase; the
// buffer memory itself is not cleared, so no clearing pass is needed.
// The parser phase survives drains and flushes, so a frame may span drains.
module api_frame_deframer_with_fifo_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_payload_byte,
  output logic                      out_frame_end,
  output logic [afd_pkg::FILL_W-1:0] out_fill_level,
  output logic                      out_is_full
);

`include "api_frame_deframer_with_fifo_unit_assert.svh"

  localparam int PW = afd_pkg::PTR_W;
  localparam int FW = afd_pkg::FILL_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_PRS  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Parser phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_FRAME  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [FW-1:0] held_r, held_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [15:0]   remain_r, remain_nxt;

  logic          out_valid_r;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_end_r, out_end_nxt;
  logic [FW-1:0] out_fill_r, out_fill_nxt;
  logic          out_load;
  logic          out_free;

  logic          in_fire;
  logic          adv;
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    rd_byte;

  // Buffer memory
  afd_ram #(
    .WIDTH(8),
    .DEPTH(afd_pkg::DEPTH),
    .AW   (PW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(in_rx_byte),
    .re   (ram_re),
    .raddr(rp_r),
    .rdata(rd_byte)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Sequence operations, walk the buffer and parse frames
  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    held_nxt     = held_r;
    phase_nxt    = phase_r;
    remain_nxt   = remain_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_load     = 1'b0;
    out_kind_nxt = afd_pkg::KIND_DONE;
    out_byte_nxt = 8'd0;
    out_end_nxt  = 1'b0;
    out_fill_nxt = held_r;
    adv          = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            afd_pkg::OP_PUT: begin
              out_load = 1'b1;
              if (held_r < FW'(afd_pkg::DEPTH)) begin
                ram_we       = 1'b1;
                wp_nxt       = (wp_r == PW'(afd_pkg::DEPTH - 1)) ? '0 : wp_r + 1'b1;
                held_nxt     = held_r + 1'b1;
                out_kind_nxt = afd_pkg::KIND_PUT_OK;
                out_fill_nxt = held_r + 1'b1;
              end else begin
                out_kind_nxt = afd_pkg::KIND_DROPPED;
              end
            end
            afd_pkg::OP_DRAIN: begin
              if (held_r != '0) begin
                state_nxt = S_RD;
              end else begin
                out_load = 1'b1;
              end
            end
            afd_pkg::OP_FLUSH: begin
              wp_nxt       = '0;
              rp_nxt       = '0;
              held_nxt     = '0;
              out_load     = 1'b1;
              out_fill_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        rp_nxt    = (rp_r == PW'(afd_pkg::DEPTH - 1)) ? '0 : rp_r + 1'b1;
        held_nxt  = held_r - 1'b1;
        state_nxt = S_PRS;
      end
      S_PRS: begin
        if (rd_byte == afd_pkg::FRAME_START) begin
          phase_nxt  = PH_LEN_HI;
          remain_nxt = '0;
        end else begin
          case (phase_r)
            PH_LEN_HI: begin
              remain_nxt = {rd_byte, 8'd0};
              phase_nxt  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              remain_nxt = remain_r | {8'd0, rd_byte};
              phase_nxt  = PH_FRAME;
            end
            PH_FRAME: begin
              if (remain_r != '0) begin
                // hold the byte until the output register frees up
                if (out_free) begin
                  remain_nxt   = remain_r - 1'b1;
                  out_load     = 1'b1;
                  out_kind_nxt = afd_pkg::KIND_PAYLOAD;
                  out_byte_nxt = rd_byte;
                  out_end_nxt  = (remain_r == 16'd1);
                end else begin
                  adv = 1'b0;
                end
              end else begin
                // swallow the checksum
                phase_nxt = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        if (adv) begin
          state_nxt = (held_r != '0) ? S_RD : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      held_r      <= '0;
      phase_r     <= PH_IDLE;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      held_r   <= held_nxt;
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output word; hold while stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_end_r  <= out_end_nxt;
      out_fill_r <= out_fill_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_end    = out_end_r;
  assign out_fill_level   = out_fill_r;
  assign out_is_full      = (out_fill_r == FW'(afd_pkg::DEPTH));

  `AFD_NEVER(a_held_bound, held_r > FW'(afd_pkg::DEPTH), "held count above depth")
  `AFD_ASSERT(a_parse_after_read, (state_r == S_PRS) |-> ($past(state_r) == S_RD || $past(state_r) == S_PRS), "parse without a memory read")
  `AFD_ASSERT(a_done_empty, (out_valid_r && out_kind_r == afd_pkg::KIND_DONE) |-> (out_fill_r == '0), "done word with bytes left")
  `AFD_ASSERT(a_end_on_payload, (out_valid_r && out_end_r) |-> (out_kind_r == afd_pkg::KIND_PAYLOAD), "frame end on a non-payload word")

endmodule
